// ===== hdl/irs_pkg.sv =====
// irs_pkg: shared types and constants of the ir sensor on/off sequencer
// command and status structs between controller and datapath, step codes,
// channel indexes and result field widths; depends on nothing
package irs_pkg;

   typedef logic [3:0] step_type;

   // cycle steps that do work
   localparam step_type STEP_EMIT_ON   = 4'd1;
   localparam step_type STEP_LIT       = 4'd3;
   localparam step_type STEP_NEAR      = 4'd5;
   localparam step_type STEP_DARK_BUMP = 4'd7;
   localparam step_type STEP_LAST      = 4'd8;
   localparam step_type STEP_ZERO      = 4'd0;
   localparam step_type STEP_ONE       = 4'd1;

   // channels, lit rings hold all seven, dark rings the first five
   localparam int NUM_LIT   = 7;
   localparam int NUM_DARK  = 5;
   localparam int CH_SIDE_L = 0;
   localparam int CH_SIDE_R = 1;
   localparam int CH_BUMP_L = 2;
   localparam int CH_BUMP_R = 3;
   localparam int CH_BUMP_F = 4;
   localparam int CH_NEAR_L = 5;
   localparam int CH_NEAR_R = 6;

   // result field widths
   localparam int DIFF_OUT_W  = 14;
   localparam int NEAR_OUT_W  = 12;
   localparam int RATIO_OUT_W = 16;

   // near signal is the difference over four, ratio is far times 100 over near
   localparam int NEAR_SHIFT    = 2;
   localparam int RATIO_SCALE   = 100;
   localparam int RATIO_SCALE_W = 7;
   localparam logic [RATIO_OUT_W-1:0] RATIO_SAT = 16'hFFFF;

   // register indexes on the csr port
   typedef logic csr_idx_type;
   localparam csr_idx_type CSR_SIDE_EMIT = 1'b0;
   localparam csr_idx_type CSR_BUMP_EMIT = 1'b1;

   typedef struct packed {
      logic capture;
      logic update;
      logic diff;
      logic mul;
      logic div_step;
      logic out_load;
   } irs_cmd_type;

   typedef struct packed {
      logic final_step;
      logic div_last;
   } irs_status_type;

endpackage

// ===== hdl/irs_ctrl.sv =====
// irs_ctrl: controller state machine of the ir sensor on/off sequencer
// sequences capture, ring update, on the last step difference, multiply and divide, and output;
// depends on irs_pkg
module irs_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  irs_pkg::irs_status_type status,
   output irs_pkg::irs_cmd_type    cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_UPDATE,
      S_DIFF,
      S_MUL,
      S_DIV,
      S_OUT
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            cmd.capture = req_valid;
            if (req_valid) begin
               state_in = S_UPDATE;
            end
         end
         S_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = status.final_step ? S_DIFF : S_OUT;
         end
         S_DIFF: begin
            cmd.diff = 1'b1;
            state_in = S_MUL;
         end
         S_MUL: begin
            cmd.mul  = 1'b1;
            state_in = S_DIV;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            cmd.out_load = !rsp_valid_ff || rsp_ready;
            if (cmd.out_load) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // at most one datapath command per cycle
   a_cmd_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0(cmd))
      else $error("irs_ctrl: more than one datapath command");

   // a captured item is always followed by its ring update
   a_capture_update: assert property (@(posedge clock) disable iff (reset)
      cmd.capture |=> cmd.update)
      else $error("irs_ctrl: capture not followed by update");

   // the output register is loaded only when free or being emptied
   a_out_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_valid_ff || rsp_ready))
      else $error("irs_ctrl: result overwritten");

   // the last divide step hands over to the output state
   a_div_end: assert property (@(posedge clock) disable iff (reset)
      (cmd.div_step && status.div_last) |=> (state_ff == S_OUT))
      else $error("irs_ctrl: divide did not finish into output");

endmodule

// ===== hdl/irs_datapath.sv =====
// irs_datapath: step counter, emitter levels, sample rings with running sums,
// differences, near signals and two bit-serial ratio dividers
// depends on irs_pkg
module irs_datapath #(
   parameter int SAMPLE_BITS = 12,
   parameter int RING_DEPTH  = 4
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  irs_pkg::irs_cmd_type                  cmd,
   output irs_pkg::irs_status_type               status,
   input  logic                                  side_emit_enable,
   input  logic                                  bump_emit_enable,
   input  logic [SAMPLE_BITS-1:0]                sample_side_right,
   input  logic [SAMPLE_BITS-1:0]                sample_side_left,
   input  logic [SAMPLE_BITS-1:0]                sample_bump_left,
   input  logic [SAMPLE_BITS-1:0]                sample_bump_right,
   input  logic [SAMPLE_BITS-1:0]                sample_bump_front,
   output logic                                  far_emitter_on,
   output logic                                  bump_emitter_on,
   output logic                                  near_emitter_on,
   output logic                                  results_valid,
   output logic [irs_pkg::DIFF_OUT_W-1:0]        diff_side_left,
   output logic [irs_pkg::DIFF_OUT_W-1:0]        diff_side_right,
   output logic [irs_pkg::DIFF_OUT_W-1:0]        diff_bump_left,
   output logic [irs_pkg::DIFF_OUT_W-1:0]        diff_bump_right,
   output logic [irs_pkg::DIFF_OUT_W-1:0]        diff_bump_front,
   output logic [irs_pkg::NEAR_OUT_W-1:0]        near_left,
   output logic [irs_pkg::RATIO_OUT_W-1:0]       ratio_left,
   output logic [irs_pkg::RATIO_OUT_W-1:0]       ratio_right
);

   localparam int SLOT_W  = $clog2(RING_DEPTH);
   localparam int SUM_W   = SAMPLE_BITS + $clog2(RING_DEPTH);
   localparam int NEAR_W  = SUM_W - irs_pkg::NEAR_SHIFT;
   localparam int PROD_W  = SUM_W + irs_pkg::RATIO_SCALE_W;
   localparam int CNT_W   = $clog2(PROD_W);
   localparam int LANES   = 2;
   localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(RING_DEPTH - 1);
   localparam logic [CNT_W-1:0]  CNT_LAST  = CNT_W'(PROD_W - 1);
   localparam logic [PROD_W-1:0] SCALE     = PROD_W'(irs_pkg::RATIO_SCALE);

   // captured item and step
   logic [SAMPLE_BITS-1:0] samp_ff [irs_pkg::NUM_LIT];
   logic [SAMPLE_BITS-1:0] samp_in [irs_pkg::NUM_LIT];
   irs_pkg::step_type      step_cnt_ff, step_cnt_in, cur_step_ff, cur_step_in;
   logic [SLOT_W-1:0]      slot_ff, slot_in;

   // rings and running sums
   logic [SAMPLE_BITS-1:0] lit_ring_ff  [irs_pkg::NUM_LIT][RING_DEPTH];
   logic [SAMPLE_BITS-1:0] lit_ring_in  [irs_pkg::NUM_LIT][RING_DEPTH];
   logic [SAMPLE_BITS-1:0] dark_ring_ff [irs_pkg::NUM_DARK][RING_DEPTH];
   logic [SAMPLE_BITS-1:0] dark_ring_in [irs_pkg::NUM_DARK][RING_DEPTH];
   logic [SUM_W-1:0]       lit_sum_ff   [irs_pkg::NUM_LIT];
   logic [SUM_W-1:0]       lit_sum_in   [irs_pkg::NUM_LIT];
   logic [SUM_W-1:0]       dark_sum_ff  [irs_pkg::NUM_DARK];
   logic [SUM_W-1:0]       dark_sum_in  [irs_pkg::NUM_DARK];
   logic [irs_pkg::NUM_LIT-1:0]  lit_wr;
   logic [irs_pkg::NUM_DARK-1:0] dark_wr;

   // emitter levels
   logic far_ff, far_in, bump_ff, bump_in, near_emit_ff, near_emit_in;

   // differences, near signals, dividers
   logic [SUM_W-1:0]  diff_ff [irs_pkg::NUM_DARK];
   logic [SUM_W-1:0]  diff_in [irs_pkg::NUM_DARK];
   logic [SUM_W-1:0]  near_abs [LANES];
   logic [NEAR_W-1:0] near_ff [LANES];
   logic [NEAR_W-1:0] near_in [LANES];
   logic [PROD_W-1:0] num_ff [LANES];
   logic [PROD_W-1:0] num_in [LANES];
   logic [PROD_W-1:0] quo_ff [LANES];
   logic [PROD_W-1:0] quo_in [LANES];
   logic [NEAR_W-1:0] rem_ff [LANES];
   logic [NEAR_W-1:0] rem_in [LANES];
   logic [NEAR_W:0]   rem_sh [LANES];
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [PROD_W+irs_pkg::RATIO_OUT_W-1:0] quo_ext [LANES];
   logic [irs_pkg::RATIO_OUT_W-1:0]        ratio_val [LANES];

   // result register
   logic                             out_far_ff, out_bump_ff, out_near_ff, out_valid_ff;
   logic                             out_far_in, out_bump_in, out_near_in, out_valid_in;
   logic [irs_pkg::DIFF_OUT_W-1:0]   out_diff_ff [irs_pkg::NUM_DARK];
   logic [irs_pkg::DIFF_OUT_W-1:0]   out_diff_in [irs_pkg::NUM_DARK];
   logic [SUM_W+irs_pkg::DIFF_OUT_W-1:0] diff_ext [irs_pkg::NUM_DARK];
   logic [NEAR_W+irs_pkg::NEAR_OUT_W-1:0] near_ext;
   logic [irs_pkg::NEAR_OUT_W-1:0]   out_nearl_ff, out_nearl_in;
   logic [irs_pkg::RATIO_OUT_W-1:0]  out_ratio_ff [LANES];
   logic [irs_pkg::RATIO_OUT_W-1:0]  out_ratio_in [LANES];

   logic final_step;

   assign final_step = (cur_step_ff == irs_pkg::STEP_LAST);

   // step counter and capture
   always_comb begin
      step_cnt_in = step_cnt_ff;
      cur_step_in = cur_step_ff;
      for (int ch = 0; ch < irs_pkg::NUM_LIT; ch++) begin
         samp_in[ch] = samp_ff[ch];
      end
      if (cmd.capture) begin
         cur_step_in = step_cnt_ff + irs_pkg::STEP_ONE;
         step_cnt_in = (cur_step_in == irs_pkg::STEP_LAST) ? irs_pkg::STEP_ZERO
                                                             : cur_step_in;
         // each channel's sample source, near channels read the side receivers
         samp_in[irs_pkg::CH_SIDE_L] = sample_side_left;
         samp_in[irs_pkg::CH_SIDE_R] = sample_side_right;
         samp_in[irs_pkg::CH_BUMP_L] = sample_bump_left;
         samp_in[irs_pkg::CH_BUMP_R] = sample_bump_right;
         samp_in[irs_pkg::CH_BUMP_F] = sample_bump_front;
         samp_in[irs_pkg::CH_NEAR_L] = sample_side_left;
         samp_in[irs_pkg::CH_NEAR_R] = sample_side_right;
      end
   end

   // which rings this step writes
   always_comb begin
      lit_wr  = '0;
      dark_wr = '0;
      for (int ch = 0; ch < irs_pkg::NUM_LIT; ch++) begin
         if (ch < irs_pkg::CH_NEAR_L) begin
            lit_wr[ch] = (cur_step_ff == irs_pkg::STEP_LIT);
         end else begin
            lit_wr[ch] = (cur_step_ff == irs_pkg::STEP_NEAR);
         end
      end
      for (int ch = 0; ch < irs_pkg::NUM_DARK; ch++) begin
         if (ch < irs_pkg::CH_BUMP_L) begin
            dark_wr[ch] = final_step;
         end else begin
            dark_wr[ch] = (cur_step_ff == irs_pkg::STEP_DARK_BUMP);
         end
      end
   end

   // ring write with running sum: drop the overwritten entry, add the new one
   always_comb begin
      lit_ring_in  = lit_ring_ff;
      dark_ring_in = dark_ring_ff;
      lit_sum_in   = lit_sum_ff;
      dark_sum_in  = dark_sum_ff;
      slot_in      = slot_ff;
      if (cmd.update) begin
         for (int ch = 0; ch < irs_pkg::NUM_LIT; ch++) begin
            if (lit_wr[ch]) begin
               lit_ring_in[ch][slot_ff] = samp_ff[ch];
               lit_sum_in[ch] = lit_sum_ff[ch] - SUM_W'(lit_ring_ff[ch][slot_ff])
                                + SUM_W'(samp_ff[ch]);
            end
         end
         for (int ch = 0; ch < irs_pkg::NUM_DARK; ch++) begin
            if (dark_wr[ch]) begin
               dark_ring_in[ch][slot_ff] = samp_ff[ch];
               dark_sum_in[ch] = dark_sum_ff[ch] - SUM_W'(dark_ring_ff[ch][slot_ff])
                                 + SUM_W'(samp_ff[ch]);
            end
         end
         if (final_step) begin
            slot_in = (slot_ff == SLOT_LAST) ? '0 : slot_ff + 1'b1;
         end
      end
   end

   // emitters, enables read at the step itself
   always_comb begin
      far_in       = far_ff;
      bump_in      = bump_ff;
      near_emit_in = near_emit_ff;
      if (cmd.update) begin
         if (cur_step_ff == irs_pkg::STEP_EMIT_ON) begin
            if (side_emit_enable) far_in = 1'b1;
            if (bump_emit_enable) bump_in = 1'b1;
         end else if (cur_step_ff == irs_pkg::STEP_LIT) begin
            far_in  = 1'b0;
            bump_in = 1'b0;
            if (side_emit_enable) near_emit_in = 1'b1;
         end else if (cur_step_ff == irs_pkg::STEP_NEAR) begin
            near_emit_in = 1'b0;
         end
      end
   end

   // absolute differences and near signals
   always_comb begin
      near_abs[0] = (lit_sum_ff[irs_pkg::CH_NEAR_L] > dark_sum_ff[irs_pkg::CH_SIDE_L])
         ? lit_sum_ff[irs_pkg::CH_NEAR_L] - dark_sum_ff[irs_pkg::CH_SIDE_L]
         : dark_sum_ff[irs_pkg::CH_SIDE_L] - lit_sum_ff[irs_pkg::CH_NEAR_L];
      near_abs[1] = (lit_sum_ff[irs_pkg::CH_NEAR_R] > dark_sum_ff[irs_pkg::CH_SIDE_R])
         ? lit_sum_ff[irs_pkg::CH_NEAR_R] - dark_sum_ff[irs_pkg::CH_SIDE_R]
         : dark_sum_ff[irs_pkg::CH_SIDE_R] - lit_sum_ff[irs_pkg::CH_NEAR_R];
      for (int k = 0; k < irs_pkg::NUM_DARK; k++) begin
         diff_in[k] = diff_ff[k];
         if (cmd.diff) begin
            diff_in[k] = (dark_sum_ff[k] > lit_sum_ff[k]) ? dark_sum_ff[k] - lit_sum_ff[k]
                                                          : lit_sum_ff[k] - dark_sum_ff[k];
         end
      end
      for (int l = 0; l < LANES; l++) begin
         near_in[l] = cmd.diff ? near_abs[l][SUM_W-1:irs_pkg::NEAR_SHIFT] : near_ff[l];
      end
   end

   // scale and restoring division, one quotient bit per cycle per lane
   always_comb begin
      cnt_in = cnt_ff;
      if (cmd.mul) begin
         cnt_in = '0;
      end else if (cmd.div_step) begin
         cnt_in = cnt_ff + 1'b1;
      end
      for (int l = 0; l < LANES; l++) begin
         rem_sh[l] = {rem_ff[l], num_ff[l][PROD_W-1]};
         num_in[l] = num_ff[l];
         quo_in[l] = quo_ff[l];
         rem_in[l] = rem_ff[l];
         if (cmd.mul) begin
            num_in[l] = PROD_W'(diff_ff[l == 0 ? irs_pkg::CH_SIDE_L : irs_pkg::CH_SIDE_R])
                        * SCALE;
            quo_in[l] = '0;
            rem_in[l] = '0;
         end else if (cmd.div_step) begin
            num_in[l] = {num_ff[l][PROD_W-2:0], 1'b0};
            if (rem_sh[l] >= {1'b0, near_ff[l]}) begin
               rem_in[l] = NEAR_W'(rem_sh[l] - {1'b0, near_ff[l]});
               quo_in[l] = {quo_ff[l][PROD_W-2:0], 1'b1};
            end else begin
               rem_in[l] = rem_sh[l][NEAR_W-1:0];
               quo_in[l] = {quo_ff[l][PROD_W-2:0], 1'b0};
            end
         end
      end
   end

   // saturate on zero divisor or a quotient beyond the field
   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         quo_ext[l] = {{irs_pkg::RATIO_OUT_W{1'b0}}, quo_ff[l]};
         if ((near_ff[l] == '0) ||
             (|quo_ext[l][PROD_W+irs_pkg::RATIO_OUT_W-1:irs_pkg::RATIO_OUT_W])) begin
            ratio_val[l] = irs_pkg::RATIO_SAT;
         end else begin
            ratio_val[l] = quo_ext[l][irs_pkg::RATIO_OUT_W-1:0];
         end
      end
   end

   // result register, numeric fields zero off the last step
   always_comb begin
      near_ext     = {{irs_pkg::NEAR_OUT_W{1'b0}}, near_ff[0]};
      out_far_in   = out_far_ff;
      out_bump_in  = out_bump_ff;
      out_near_in  = out_near_ff;
      out_valid_in = out_valid_ff;
      out_nearl_in = out_nearl_ff;
      for (int k = 0; k < irs_pkg::NUM_DARK; k++) begin
         diff_ext[k]    = {{irs_pkg::DIFF_OUT_W{1'b0}}, diff_ff[k]};
         out_diff_in[k] = out_diff_ff[k];
      end
      for (int l = 0; l < LANES; l++) begin
         out_ratio_in[l] = out_ratio_ff[l];
      end
      if (cmd.out_load) begin
         out_far_in   = far_ff;
         out_bump_in  = bump_ff;
         out_near_in  = near_emit_ff;
         out_valid_in = final_step;
         out_nearl_in = final_step ? near_ext[irs_pkg::NEAR_OUT_W-1:0] : '0;
         for (int k = 0; k < irs_pkg::NUM_DARK; k++) begin
            out_diff_in[k] = final_step ? diff_ext[k][irs_pkg::DIFF_OUT_W-1:0] : '0;
         end
         for (int l = 0; l < LANES; l++) begin
            out_ratio_in[l] = final_step ? ratio_val[l] : '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_cnt_ff  <= irs_pkg::STEP_ZERO;
         cur_step_ff  <= irs_pkg::STEP_ZERO;
         slot_ff      <= '0;
         far_ff       <= 1'b0;
         bump_ff      <= 1'b0;
         near_emit_ff <= 1'b0;
         lit_ring_ff  <= '{default: '{default: '0}};
         dark_ring_ff <= '{default: '{default: '0}};
         lit_sum_ff   <= '{default: '0};
         dark_sum_ff  <= '{default: '0};
      end else begin
         step_cnt_ff  <= step_cnt_in;
         cur_step_ff  <= cur_step_in;
         slot_ff      <= slot_in;
         far_ff       <= far_in;
         bump_ff      <= bump_in;
         near_emit_ff <= near_emit_in;
         lit_ring_ff  <= lit_ring_in;
         dark_ring_ff <= dark_ring_in;
         lit_sum_ff   <= lit_sum_in;
         dark_sum_ff  <= dark_sum_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      samp_ff      <= samp_in;
      diff_ff      <= diff_in;
      near_ff      <= near_in;
      num_ff       <= num_in;
      quo_ff       <= quo_in;
      rem_ff       <= rem_in;
      cnt_ff       <= cnt_in;
      out_far_ff   <= out_far_in;
      out_bump_ff  <= out_bump_in;
      out_near_ff  <= out_near_in;
      out_valid_ff <= out_valid_in;
      out_diff_ff  <= out_diff_in;
      out_nearl_ff <= out_nearl_in;
      out_ratio_ff <= out_ratio_in;
   end

   assign status.final_step = final_step;
   assign status.div_last   = (cnt_ff == CNT_LAST);

   assign far_emitter_on  = out_far_ff;
   assign bump_emitter_on = out_bump_ff;
   assign near_emitter_on = out_near_ff;
   assign results_valid   = out_valid_ff;
   assign diff_side_left  = out_diff_ff[irs_pkg::CH_SIDE_L];
   assign diff_side_right = out_diff_ff[irs_pkg::CH_SIDE_R];
   assign diff_bump_left  = out_diff_ff[irs_pkg::CH_BUMP_L];
   assign diff_bump_right = out_diff_ff[irs_pkg::CH_BUMP_R];
   assign diff_bump_front = out_diff_ff[irs_pkg::CH_BUMP_F];
   assign near_left       = out_nearl_ff;
   assign ratio_left      = out_ratio_ff[0];
   assign ratio_right     = out_ratio_ff[1];

endmodule

// ===== hdl/ir_sensor_on_off_sequencer.sv =====
// sequence: an item is captured, its rings are updated and its result is loaded into
//   the output register; a step-eight item also passes through difference, multiply
//   and the bit-serial ratio divider, one quotient bit a cycle over SUM_W + 7 bits
// flow: a new item is taken only once the last result is in the output register
// reset: synchronous, active high; clears step, ring slot, rings, sums, emitters
//   and enables at once, no clearing pass
// ir_sensor_on_off_sequencer: top level, csr registers plus controller and datapath
// depends on irs_pkg, irs_ctrl and irs_datapath
module ir_sensor_on_off_sequencer #(
   parameter int SAMPLE_BITS = 12,
   parameter int RING_DEPTH  = 4
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // input channel: one tick carrying five adc samples
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [SAMPLE_BITS-1:0]                req_sample_side_right,
   input  logic [SAMPLE_BITS-1:0]                req_sample_side_left,
   input  logic [SAMPLE_BITS-1:0]                req_sample_bump_left,
   input  logic [SAMPLE_BITS-1:0]                req_sample_bump_right,
   input  logic [SAMPLE_BITS-1:0]                req_sample_bump_front,
   // result channel: one item per tick
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic                                  rsp_far_emitter_on,
   output logic                                  rsp_bump_emitter_on,
   output logic                                  rsp_near_emitter_on,
   output logic                                  rsp_results_valid,
   output logic [irs_pkg::DIFF_OUT_W-1:0]        rsp_diff_side_left,
   output logic [irs_pkg::DIFF_OUT_W-1:0]        rsp_diff_side_right,
   output logic [irs_pkg::DIFF_OUT_W-1:0]        rsp_diff_bump_left,
   output logic [irs_pkg::DIFF_OUT_W-1:0]        rsp_diff_bump_right,
   output logic [irs_pkg::DIFF_OUT_W-1:0]        rsp_diff_bump_front,
   output logic [irs_pkg::NEAR_OUT_W-1:0]        rsp_near_left,
   output logic [irs_pkg::RATIO_OUT_W-1:0]       rsp_ratio_left,
   output logic [irs_pkg::RATIO_OUT_W-1:0]       rsp_ratio_right,
   // csr port, side enable at 0x0, bump enable at 0x4
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [2:0]                            csr_paddr,
   input  logic [31:0]                           csr_pwdata,
   output logic [31:0]                           csr_prdata,
   output logic                                  csr_pready
);

   irs_pkg::irs_cmd_type    cmd;
   irs_pkg::irs_status_type status;

   logic side_en_ff, side_en_in;
   logic bump_en_ff, bump_en_in;
   logic csr_wr;
   irs_pkg::csr_idx_type csr_idx;

   // register index comes from the word address bit
   assign csr_idx    = csr_paddr[2];
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   always_comb begin
      side_en_in = side_en_ff;
      bump_en_in = bump_en_ff;
      if (csr_wr) begin
         unique case (csr_idx)
            irs_pkg::CSR_SIDE_EMIT: side_en_in = csr_pwdata[0];
            irs_pkg::CSR_BUMP_EMIT: bump_en_in = csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         irs_pkg::CSR_SIDE_EMIT: csr_prdata = {31'b0, side_en_ff};
         irs_pkg::CSR_BUMP_EMIT: csr_prdata = {31'b0, bump_en_ff};
         default:                csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         side_en_ff <= 1'b0;
         bump_en_ff <= 1'b0;
      end else begin
         side_en_ff <= side_en_in;
         bump_en_ff <= bump_en_in;
      end
   end

   // controller: one item at a time, output register frees the input side
   irs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath: rings, sums, differences, dividers and the result register
   irs_datapath #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .RING_DEPTH  (RING_DEPTH)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .side_emit_enable  (side_en_ff),
      .bump_emit_enable  (bump_en_ff),
      .sample_side_right (req_sample_side_right),
      .sample_side_left  (req_sample_side_left),
      .sample_bump_left  (req_sample_bump_left),
      .sample_bump_right (req_sample_bump_right),
      .sample_bump_front (req_sample_bump_front),
      .far_emitter_on    (rsp_far_emitter_on),
      .bump_emitter_on   (rsp_bump_emitter_on),
      .near_emitter_on   (rsp_near_emitter_on),
      .results_valid     (rsp_results_valid),
      .diff_side_left    (rsp_diff_side_left),
      .diff_side_right   (rsp_diff_side_right),
      .diff_bump_left    (rsp_diff_bump_left),
      .diff_bump_right   (rsp_diff_bump_right),
      .diff_bump_front   (rsp_diff_bump_front),
      .near_left         (rsp_near_left),
      .ratio_left        (rsp_ratio_left),
      .ratio_right       (rsp_ratio_right)
   );

endmodule
